[hdl/lgt_pkg.sv]
// ----------------------------------------------------------------------------
// Life generation engine: shared package
// Cell codes, request modes, register indexes and the payload and window
// types used by the engine and its rule unit.
// ----------------------------------------------------------------------------
package lgt_pkg;

  // Cell encoding.
  localparam logic [1:0] CELL_DEAD   = 2'd0;
  localparam logic [1:0] CELL_ALIVE  = 2'd1;
  localparam logic [1:0] CELL_SECOND = 2'd2;
  localparam logic [1:0] CELL_RECENT = 2'd3;

  // Request modes.
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_STEP  = 2'd2;

  // Configuration register indexes.
  localparam logic REG_RECENT_DEAD = 1'b0;
  localparam logic REG_TWO_SPECIES = 1'b1;

  // Width of the population counts, and their saturation value.
  localparam int unsigned COUNT_W = 13;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Neighbourhood rule thresholds.
  localparam logic [3:0] BIRTH_COUNT = 4'd3;
  localparam logic [3:0] KEEP_COUNT  = 4'd2;

  // Columns fetched ahead of the first cell of each row.
  localparam logic [1:0] PRIME_COLS = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RDATA,
    ST_FETCH,
    ST_DONE
  } lgt_state_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [5:0] row;
    logic [5:0] col;
    logic [1:0] cell_in;
  } lgt_in_t;

  typedef struct packed {
    logic [1:0]         cell_out;
    logic [COUNT_W-1:0] count_first;
    logic [COUNT_W-1:0] count_second;
  } lgt_out_t;

  typedef struct packed {
    logic recent_dead_enable;
    logic two_species;
  } lgt_cfg_t;

  // 3x3 neighbourhood: [column][row] with index 0 left/up, 2 right/down.
  typedef logic [2:0][2:0][1:0] lgt_win_t;

endpackage

[hdl/lgt_rule.sv]
// ----------------------------------------------------------------------------
// Life generation engine: rule unit
// Counts both species over the eight neighbours of a 3x3 window and
// returns the next value of the centre cell.
// ----------------------------------------------------------------------------
module lgt_rule (
  input  lgt_pkg::lgt_cfg_t cfg_i,
  input  lgt_pkg::lgt_win_t win_i,
  output logic [1:0]        next_o
);
  import lgt_pkg::*;

  logic [3:0] first;
  logic [3:0] second;
  logic [3:0] total;
  logic [1:0] centre;

  // Count neighbours of each species, skipping the centre.
  always_comb begin
    first  = '0;
    second = '0;
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        if (!(j == 1 && k == 1)) begin
          if (win_i[j][k] == CELL_ALIVE) begin
            first = first + 4'd1;
          end else if (win_i[j][k] == CELL_SECOND) begin
            second = second + 4'd1;
          end
        end
      end
    end
  end

  assign total  = first + second;
  assign centre = win_i[1][1];

  // Apply either the two-species majority rule or the plain rule.
  always_comb begin
    if (cfg_i.two_species) begin
      if (total == BIRTH_COUNT) begin
        next_o = (first > second) ? CELL_ALIVE : CELL_SECOND;
      end else if (total == KEEP_COUNT) begin
        next_o = centre;
      end else begin
        next_o = CELL_DEAD;
      end
    end else begin
      if (first == BIRTH_COUNT) begin
        next_o = CELL_ALIVE;
      end else if (first == KEEP_COUNT) begin
        next_o = centre;
      end else if (cfg_i.recent_dead_enable && centre == CELL_ALIVE) begin
        next_o = CELL_RECENT;
      end else begin
        next_o = CELL_DEAD;
      end
    end
  end

endmodule

[hdl/life_generation_torus.sv]
// ----------------------------------------------------------------------------
// Life generation engine on a toroidal grid
// Holds the grid in a two-bank memory and advances it one generation per
// step request through a sliding 3x3 window and a shared rule unit.
// ----------------------------------------------------------------------------
// Usage:
// A request on in_req_i is taken when in_valid_i is high and in_stall_o low.
// It writes a cell, reads a cell or advances the grid by one generation.
// Every request gives exactly one result on out_req_o, handed over when
// out_valid_o is high and out_stall_i low. One request is worked on at a
// time; in_stall_o stays high until its result is in the output register.
// A step fetches, through the single memory read port, one new window
// column of three cells per cell, plus two extra columns per row.
// The new generation goes into the other bank, so no copy pass is needed.
// Configuration writes on cfg_we_i are taken in any cycle; they are meant
// to be made while the engine is idle.
// After reset the engine clears the grid in bank zero, one cell a cycle,
// and stalls input meanwhile. A stalled result waits in the output
// register; the engine may already take the next request, which then
// waits for that register to free up.
// ----------------------------------------------------------------------------
module life_generation_torus #(
  parameter int GRID_ROWS = 64,
  parameter int GRID_COLS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lgt_pkg::lgt_in_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lgt_pkg::lgt_out_t out_req_o,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic              cfg_data_i
);
  import lgt_pkg::*;

  localparam int RW = $clog2(GRID_ROWS);
  localparam int CW = $clog2(GRID_COLS);
  localparam int AW = 1 + RW + CW;
  localparam logic [RW-1:0] ROW_LAST = RW'(GRID_ROWS - 1);
  localparam logic [CW-1:0] COL_LAST = CW'(GRID_COLS - 1);

  // Control state.
  lgt_state_e state_q, state_d;
  logic [RW-1:0] r_q, r_d;
  logic [CW-1:0] c_q, c_d;
  logic [CW-1:0] fc_q, fc_d;
  logic [1:0]    ph_q, ph_d;
  logic [1:0]    prime_q, prime_d;
  logic          sel_q, sel_d;
  logic          out_valid_q, out_valid_d;
  lgt_cfg_t      cfg_q, cfg_d;

  // Datapath registers.
  logic [COUNT_W-1:0] cnt1_q, cnt1_d;
  logic [COUNT_W-1:0] cnt2_q, cnt2_d;
  logic [1:0]         nc_up_q, nc_up_d;
  logic [1:0]         nc_mid_q, nc_mid_d;
  lgt_win_t           win_q, win_d;
  lgt_out_t           res_q, res_d;
  lgt_out_t           out_q, out_d;
  logic               inside_q, inside_d;

  // Memory ports.
  logic [1:0]    mem [2**AW];
  logic [1:0]    rdata_q;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic [1:0]    wdata;
  logic          we;

  // Helpers.
  logic               accept;
  logic               load;
  logic               in_inside;
  logic [RW-1:0]      r_up;
  logic [RW-1:0]      r_dn;
  logic [RW-1:0]      r_fetch;
  logic [CW-1:0]      fc_inc;
  logic               eval;
  logic               last_cell;
  lgt_win_t           win_sh;
  logic [1:0]         next_cell;
  logic [COUNT_W-1:0] cnt1_nx;
  logic [COUNT_W-1:0] cnt2_nx;

  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign load        = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  assign in_inside = (int'(in_req_i.row) < GRID_ROWS) && (int'(in_req_i.col) < GRID_COLS);

  // Toroidal neighbour rows and the next column to fetch.
  assign r_up   = (r_q == '0) ? ROW_LAST : r_q - 1'b1;
  assign r_dn   = (r_q == ROW_LAST) ? '0 : r_q + 1'b1;
  assign fc_inc = (fc_q == COL_LAST) ? '0 : fc_q + 1'b1;

  always_comb begin
    case (ph_q)
      2'd0:    r_fetch = r_up;
      2'd1:    r_fetch = r_q;
      default: r_fetch = r_dn;
    endcase
  end

  // The window after shifting in the freshly fetched column.
  always_comb begin
    win_sh       = win_q;
    win_sh[0]    = win_q[1];
    win_sh[1]    = win_q[2];
    win_sh[2][0] = nc_up_q;
    win_sh[2][1] = nc_mid_q;
    win_sh[2][2] = rdata_q;
  end

  lgt_rule u_rule (
    .cfg_i  (cfg_q),
    .win_i  (win_sh),
    .next_o (next_cell)
  );

  assign eval      = (state_q == ST_FETCH) && (ph_q == 2'd3) && (prime_q == '0);
  assign last_cell = (r_q == ROW_LAST) && (c_q == COL_LAST);

  // Saturating population counts including the cell now evaluated.
  always_comb begin
    cnt1_nx = cnt1_q;
    cnt2_nx = cnt2_q;
    if (next_cell == CELL_ALIVE && cnt1_q != COUNT_MAX) begin
      cnt1_nx = cnt1_q + 1'b1;
    end
    if (next_cell == CELL_SECOND && cnt2_q != COUNT_MAX) begin
      cnt2_nx = cnt2_q + 1'b1;
    end
  end

  // Memory address and write selection.
  always_comb begin
    raddr = '0;
    waddr = '0;
    wdata = CELL_DEAD;
    we    = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = {1'b0, r_q, c_q};
      end
      ST_IDLE: begin
        raddr = {sel_q, RW'(in_req_i.row), CW'(in_req_i.col)};
        waddr = {sel_q, RW'(in_req_i.row), CW'(in_req_i.col)};
        wdata = in_req_i.cell_in;
        we    = accept && (in_req_i.mode == MODE_WRITE) && in_inside;
      end
      ST_FETCH: begin
        raddr = {sel_q, r_fetch, fc_q};
        waddr = {~sel_q, r_q, c_q};
        wdata = next_cell;
        we    = eval;
      end
      ST_RDATA, ST_DONE: begin
        we = 1'b0;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Grid memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (r_q == ROW_LAST && c_q == COL_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_req_i.mode == MODE_READ) begin
            state_d = ST_RDATA;
          end else if (in_req_i.mode == MODE_STEP) begin
            state_d = ST_FETCH;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_RDATA: state_d = ST_DONE;
      ST_FETCH: begin
        if (eval && last_cell) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Counters, window and result registers.
  always_comb begin
    r_d         = r_q;
    c_d         = c_q;
    fc_d        = fc_q;
    ph_d        = ph_q;
    prime_d     = prime_q;
    sel_d       = sel_q;
    cnt1_d      = cnt1_q;
    cnt2_d      = cnt2_q;
    nc_up_d     = nc_up_q;
    nc_mid_d    = nc_mid_q;
    win_d       = win_q;
    res_d       = res_q;
    inside_d    = inside_q;
    out_d       = out_q;
    out_valid_d = (out_valid_q && out_stall_i) || load;
    cfg_d       = cfg_q;

    // Configuration writes.
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_RECENT_DEAD: cfg_d.recent_dead_enable = cfg_data_i;
        REG_TWO_SPECIES: cfg_d.two_species        = cfg_data_i;
        default:         cfg_d                    = cfg_q;
      endcase
    end

    if (load) begin
      out_d = res_q;
    end

    unique case (state_q)
      ST_CLEAR: begin
        // Sweep every grid cell of bank zero.
        if (c_q == COL_LAST) begin
          c_d = '0;
          r_d = (r_q == ROW_LAST) ? '0 : r_q + 1'b1;
        end else begin
          c_d = c_q + 1'b1;
        end
      end
      ST_IDLE: begin
        res_d    = '0;
        inside_d = in_inside;
        r_d      = '0;
        c_d      = '0;
        fc_d     = COL_LAST;
        ph_d     = '0;
        prime_d  = PRIME_COLS;
        cnt1_d   = '0;
        cnt2_d   = '0;
      end
      ST_RDATA: begin
        res_d.cell_out = inside_q ? rdata_q : CELL_DEAD;
      end
      ST_FETCH: begin
        // Three reads per column; the read data is registered, so it arrives in the cycle after its address.
        ph_d = ph_q + 1'b1;
        if (ph_q == 2'd1) begin
          nc_up_d = rdata_q;
        end
        if (ph_q == 2'd2) begin
          nc_mid_d = rdata_q;
        end
        if (ph_q == 2'd3) begin
          win_d = win_sh;
          fc_d  = fc_inc;
          if (prime_q != '0) begin
            prime_d = prime_q - 1'b1;
          end else begin
            cnt1_d = cnt1_nx;
            cnt2_d = cnt2_nx;
            if (c_q == COL_LAST) begin
              c_d     = '0;
              fc_d    = COL_LAST;
              prime_d = PRIME_COLS;
              if (r_q == ROW_LAST) begin
                r_d                = '0;
                sel_d              = ~sel_q;
                res_d.cell_out     = CELL_DEAD;
                res_d.count_first  = cnt1_nx;
                res_d.count_second = cnt2_nx;
              end else begin
                r_d = r_q + 1'b1;
              end
            end else begin
              c_d = c_q + 1'b1;
            end
          end
        end
      end
      ST_DONE: begin
        res_d = res_q;
      end
      default: begin
        res_d = res_q;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      r_q         <= '0;
      c_q         <= '0;
      fc_q        <= '0;
      ph_q        <= '0;
      prime_q     <= '0;
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
      cfg_q       <= '0;
    end else begin
      state_q     <= state_d;
      r_q         <= r_d;
      c_q         <= c_d;
      fc_q        <= fc_d;
      ph_q        <= ph_d;
      prime_q     <= prime_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
      cfg_q       <= cfg_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cnt1_q   <= cnt1_d;
    cnt2_q   <= cnt2_d;
    nc_up_q  <= nc_up_d;
    nc_mid_q <= nc_mid_d;
    win_q    <= win_d;
    res_q    <= res_d;
    inside_q <= inside_d;
    out_q    <= out_d;
  end

endmodule

[hdl/lgt_checker.sv]
// ----------------------------------------------------------------------------
// Life generation engine: port checker
// Watches the request and result channels of the engine over time.
// ----------------------------------------------------------------------------
module lgt_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input lgt_pkg::lgt_out_t out_req_o
);
  import lgt_pkg::*;

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_req_o))
    else $error("result changed while stalled");

  // Only one request is worked on at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken while busy");

  // A result with a cell value other than dead carries no counts.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_req_o.cell_out != CELL_DEAD) |->
      (out_req_o.count_first == '0) && (out_req_o.count_second == '0))
    else $error("cell value and counts in one result");

  // The grid clearing pass holds off requests straight after reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> in_stall_o)
    else $error("request taken before grid clear");

endmodule

bind life_generation_torus lgt_checker u_lgt_checker (.*);

[test/tb_life_generation_torus.sv]
// ----------------------------------------------------------------------------
// Testbench for the toroidal life generation engine
// A queue-fed driver sends write, read, step and unused-mode requests, and a
// monitor checks every result against a grid predictor kept in the bench.
// The run goes through all rule settings with varied idling on both sides.
// ----------------------------------------------------------------------------
module tb_life_generation_torus;
  import lgt_pkg::*;

  localparam int ROWS = 64;
  localparam int COLS = 64;
  // The fourth mode has no name in the package; it must leave the grid alone.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  // The watchdog's quiet limit lies well above the length of a step or of the clearing pass.
  localparam int QUIET_LIMIT = 60000;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  lgt_in_t  in_req_i    = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  lgt_out_t out_req_o;
  logic     cfg_we_i    = 1'b0;
  logic     cfg_index_i = 1'b0;
  logic     cfg_data_i  = 1'b0;

  // Requests waiting to be sent, and results the engine still owes.
  lgt_in_t    queued_requests[$];
  lgt_out_t   awaited_results[$];

  // Predicted grid and rule settings.
  logic [1:0] life_grid [ROWS][COLS] = '{default: '{default: CELL_DEAD}};
  logic       rule_recent = 1'b0;
  logic       rule_two    = 1'b0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches    = 0;
  int quiet_cycles  = 0;

  life_generation_torus #(
    .GRID_ROWS(ROWS),
    .GRID_COLS(COLS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_req_o  (out_req_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Applies one request to the predicted grid and returns the result it owes.
  function automatic lgt_out_t predict_result(lgt_in_t req);
    lgt_out_t   res;
    logic [1:0] fresh [ROWS][COLS];
    logic [1:0] cur;
    logic [1:0] v;
    int unsigned n1, n2, tot, pop1, pop2;
    res = '0;
    case (req.mode)
      MODE_WRITE: life_grid[req.row][req.col] = req.cell_in;
      MODE_READ:  res.cell_out = life_grid[req.row][req.col];
      MODE_STEP: begin
        for (int r = 0; r < ROWS; r++) begin
          for (int c = 0; c < COLS; c++) begin
            n1 = 0;
            n2 = 0;
            for (int dr = -1; dr <= 1; dr++) begin
              for (int dc = -1; dc <= 1; dc++) begin
                if (dr != 0 || dc != 0) begin
                  v = life_grid[(r + dr + ROWS) % ROWS][(c + dc + COLS) % COLS];
                  if (v == CELL_ALIVE) n1++;
                  else if (v == CELL_SECOND) n2++;
                end
              end
            end
            cur = life_grid[r][c];
            tot = n1 + n2;
            if (rule_two) begin
              // Majority rule: a birth takes the stronger species.
              if (tot == BIRTH_COUNT) fresh[r][c] = (n1 > n2) ? CELL_ALIVE : CELL_SECOND;
              else if (tot == KEEP_COUNT) fresh[r][c] = cur;
              else fresh[r][c] = CELL_DEAD;
            end else if (n1 == BIRTH_COUNT) begin
              fresh[r][c] = CELL_ALIVE;
            end else if (n1 == KEEP_COUNT) begin
              fresh[r][c] = cur;
            end else if (rule_recent && cur == CELL_ALIVE) begin
              fresh[r][c] = CELL_RECENT;
            end else begin
              fresh[r][c] = CELL_DEAD;
            end
          end
        end
        pop1 = 0;
        pop2 = 0;
        for (int r = 0; r < ROWS; r++) begin
          for (int c = 0; c < COLS; c++) begin
            life_grid[r][c] = fresh[r][c];
            if (fresh[r][c] == CELL_ALIVE) pop1++;
            else if (fresh[r][c] == CELL_SECOND) pop2++;
          end
        end
        res.count_first  = (pop1 > COUNT_MAX) ? COUNT_MAX : pop1[COUNT_W-1:0];
        res.count_second = (pop2 > COUNT_MAX) ? COUNT_MAX : pop2[COUNT_W-1:0];
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void queue_request(logic [1:0] m, logic [5:0] r, logic [5:0] c,
                                        logic [1:0] v);
    lgt_in_t req;
    req.mode    = m;
    req.row     = r;
    req.col     = c;
    req.cell_in = v;
    queued_requests.push_back(req);
  endfunction

  task automatic check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Waits until every queued request has been sent and answered. Each request
  // gives a result, so the engine is idle once the last one has been taken.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (queued_requests.size() != 0 || in_valid_i || awaited_results.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_RECENT_DEAD: rule_recent = val;
      REG_TWO_SPECIES: rule_two    = val;
    endcase
  endtask

  // Mostly small clusters of live cells, often across the wrapping edges,
  // followed by reads around them and now and then a step; the rest is noise.
  task automatic fill_random_phase(int n_items);
    int         made;
    int         steps_left;
    int         k;
    int         pick;
    logic [5:0] r0, c0;
    logic [1:0] v;
    logic [1:0] m;
    made       = 0;
    steps_left = 4;
    @(negedge clk_i);
    while (made < n_items) begin
      if ($urandom_range(0, 99) < 70) begin
        if ($urandom_range(0, 1) != 0) begin
          r0 = $urandom_range(0, 1) ? 6'($urandom_range(0, 1)) : 6'($urandom_range(62, 63));
          c0 = $urandom_range(0, 1) ? 6'($urandom_range(0, 1)) : 6'($urandom_range(62, 63));
        end else begin
          r0 = 6'($urandom_range(0, 63));
          c0 = 6'($urandom_range(0, 63));
        end
        k = $urandom_range(3, 6);
        repeat (k) begin
          pick = $urandom_range(0, 99);
          if (pick < 50) v = CELL_ALIVE;
          else if (pick < 80) v = CELL_SECOND;
          else if (pick < 92) v = CELL_RECENT;
          else v = CELL_DEAD;
          queue_request(MODE_WRITE, r0 + 6'($urandom_range(0, 2)) - 6'd1,
                        c0 + 6'($urandom_range(0, 2)) - 6'd1, v);
        end
        made += k;
        if (steps_left > 0 && $urandom_range(0, 2) == 0) begin
          queue_request(MODE_STEP, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                        2'($urandom_range(0, 3)));
          steps_left--;
          made++;
        end
        k = $urandom_range(2, 4);
        repeat (k) begin
          queue_request(MODE_READ, r0 + 6'($urandom_range(0, 2)) - 6'd1,
                        c0 + 6'($urandom_range(0, 2)) - 6'd1, 2'($urandom_range(0, 3)));
        end
        made += k;
      end else begin
        m = 2'($urandom_range(0, 3));
        if (m == MODE_STEP && steps_left == 0) m = MODE_READ;
        if (m == MODE_STEP) steps_left--;
        queue_request(m, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                      2'($urandom_range(0, 3)));
        made++;
      end
    end
    if (steps_left == 4) queue_request(MODE_STEP, 6'd0, 6'd0, CELL_DEAD);
  endtask

  // Driver: presents queued requests and predicts each one as it is taken.
  always @(posedge clk_i or negedge rst_ni) begin : drive
    logic taken;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_req_i   <= '0;
    end else begin
      taken = in_valid_i && !in_stall_o;
      if (taken) awaited_results.push_back(predict_result(in_req_i));
      if (!in_valid_i || taken) begin
        if (queued_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_req_i   <= queued_requests.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each result taken with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin : observe
    lgt_out_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_req_o);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          check_field("cell_out", want.cell_out, out_req_o.cell_out);
          check_field("count_first", want.count_first, out_req_o.count_first);
          check_field("count_second", want.count_second, out_req_o.count_second);
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Watchdog: ends the run when nothing has moved for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : sequencer
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part under the plain single-species rule.
    send_idle_pct = 26;
    recv_idle_pct = 70;
    write_reg(REG_RECENT_DEAD, 1'b0);
    write_reg(REG_TWO_SPECIES, 1'b0);
    @(negedge clk_i);
    queue_request(MODE_READ, 6'd0, 6'd0, CELL_DEAD);
    queue_request(MODE_READ, 6'd63, 6'd63, CELL_RECENT);
    queue_request(MODE_UNUSED, 6'd63, 6'd63, CELL_RECENT);
    // Blinker standing on the wrapping column, flanked by a second-species
    // cell that should be born as first species.
    queue_request(MODE_WRITE, 6'd63, 6'd63, CELL_ALIVE);
    queue_request(MODE_WRITE, 6'd0, 6'd63, CELL_ALIVE);
    queue_request(MODE_WRITE, 6'd1, 6'd63, CELL_ALIVE);
    queue_request(MODE_WRITE, 6'd0, 6'd0, CELL_SECOND);
    // An isolated recent-dead cell, and a second-species cell kept on two.
    queue_request(MODE_WRITE, 6'd32, 6'd32, CELL_RECENT);
    queue_request(MODE_WRITE, 6'd9, 6'd9, CELL_ALIVE);
    queue_request(MODE_WRITE, 6'd9, 6'd11, CELL_ALIVE);
    queue_request(MODE_WRITE, 6'd10, 6'd10, CELL_SECOND);
    queue_request(MODE_STEP, 6'd0, 6'd0, CELL_DEAD);
    queue_request(MODE_READ, 6'd0, 6'd62, CELL_DEAD);
    queue_request(MODE_READ, 6'd0, 6'd0, CELL_DEAD);
    queue_request(MODE_READ, 6'd63, 6'd63, CELL_DEAD);
    queue_request(MODE_READ, 6'd10, 6'd10, CELL_DEAD);
    queue_request(MODE_READ, 6'd32, 6'd32, CELL_DEAD);
    queue_request(MODE_READ, 6'd9, 6'd9, CELL_DEAD);
    queue_request(MODE_WRITE, 6'd63, 6'd0, CELL_RECENT);
    queue_request(MODE_READ, 6'd63, 6'd0, CELL_RECENT);
    queue_request(MODE_STEP, 6'd63, 6'd63, CELL_RECENT);
    queue_request(MODE_READ, 6'd1, 6'd63, CELL_DEAD);
    queue_request(MODE_READ, 6'd63, 6'd0, CELL_DEAD);
    wait_drained();

    // Single-species rule with recent-dead marks.
    write_reg(REG_RECENT_DEAD, 1'b1);
    fill_random_phase(40);
    wait_drained();

    // Two-species rule; the receiver now stalls less than the sender idles.
    send_idle_pct = 70;
    recv_idle_pct = 26;
    write_reg(REG_RECENT_DEAD, 1'b0);
    write_reg(REG_TWO_SPECIES, 1'b1);
    fill_random_phase(40);
    wait_drained();

    // Both options set, with no idling on either side.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_RECENT_DEAD, 1'b1);
    fill_random_phase(40);
    wait_drained();

    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[life_generation_torus.f]
hdl/lgt_pkg.sv
hdl/lgt_rule.sv
hdl/life_generation_torus.sv
hdl/lgt_checker.sv
test/tb_life_generation_torus.sv
